/* rtl/pai_pkg.sv */
// Shared types and constants for the positional array insert/delete block.
`default_nettype none

package pai_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WORD_W   = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         element_count;
  } res_t;

endpackage

`default_nettype wire

/* rtl/pai_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/pai_ctrl.sv */
// Request sequencer: checks, shifts through the RAM, writes back, reports.
`default_nettype none

module pai_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire pai_pkg::req_t                req,
  output logic                              done,
  output pai_pkg::res_t                     res,
  output logic                              mem_we,
  output logic [pai_pkg::ADDR_W-1:0]        mem_waddr,
  output logic [pai_pkg::WORD_W-1:0]        mem_wdata,
  output logic [pai_pkg::ADDR_W-1:0]        mem_raddr,
  input  wire logic [pai_pkg::WORD_W-1:0]   mem_rdata
);

  typedef enum logic [2:0] {IDLE, SHIFT, DRAIN, PUT, RDWAIT} state_t;

  state_t                        state;
  logic [pai_pkg::CNT_W-1:0]     count;
  logic [pai_pkg::ADDR_W-1:0]    ptr;
  logic [pai_pkg::ADDR_W-1:0]    last;
  logic [pai_pkg::ADDR_W-1:0]    pos_r;
  logic [pai_pkg::WORD_W-1:0]    value_r;
  logic                          ins;
  logic                          pend_valid;
  logic [pai_pkg::ADDR_W-1:0]    pend_addr;
  logic [1:0]                    status_r;
  logic [pai_pkg::WORD_W-1:0]    rd_r;

  logic [pai_pkg::CMP_W-1:0]     cnt_c;
  logic [pai_pkg::CMP_W-1:0]     pos_c;

  assign busy  = (state != IDLE);
  assign cnt_c = pai_pkg::CMP_W'(count);
  assign pos_c = pai_pkg::CMP_W'(req.position);

  assign mem_raddr = (state == IDLE) ? pai_pkg::ADDR_W'(req.position) : ptr;
  assign mem_we    = pend_valid || (state == PUT);
  assign mem_waddr = pend_valid ? pend_addr : pos_r;
  assign mem_wdata = pend_valid ? mem_rdata : value_r;

  assign res.status        = status_r;
  assign res.read_value    = rd_r;
  assign res.element_count = pai_pkg::POS_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      done       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            pos_r    <= pai_pkg::ADDR_W'(req.position);
            value_r  <= req.value;
            rd_r     <= '0;
            status_r <= pai_pkg::ST_OK;
            unique case (req.req_type)
              pai_pkg::REQ_INSERT: begin
                ins <= 1'b1;
                if (count == pai_pkg::CNT_W'(pai_pkg::CAPACITY)) begin
                  status_r <= pai_pkg::ST_FULL;
                  done     <= 1'b1;
                end else if (pos_c > cnt_c) begin
                  status_r <= pai_pkg::ST_RANGE;
                  done     <= 1'b1;
                end else if (pos_c == cnt_c) begin
                  state <= PUT;
                end else begin
                  ptr   <= pai_pkg::ADDR_W'(count - 1'b1);
                  last  <= pai_pkg::ADDR_W'(req.position);
                  state <= SHIFT;
                end
              end
              pai_pkg::REQ_DELETE: begin
                ins <= 1'b0;
                if (count == '0) begin
                  status_r <= pai_pkg::ST_EMPTY;
                  done     <= 1'b1;
                end else if (pos_c >= cnt_c) begin
                  status_r <= pai_pkg::ST_RANGE;
                  done     <= 1'b1;
                end else if (pos_c == cnt_c - 1'b1) begin
                  count <= count - 1'b1;
                  done  <= 1'b1;
                end else begin
                  ptr   <= pai_pkg::ADDR_W'(req.position) + 1'b1;
                  last  <= pai_pkg::ADDR_W'(count - 1'b1);
                  state <= SHIFT;
                end
              end
              pai_pkg::REQ_READ: begin
                if (count == '0) begin
                  status_r <= pai_pkg::ST_EMPTY;
                  done     <= 1'b1;
                end else if (pos_c >= cnt_c) begin
                  status_r <= pai_pkg::ST_RANGE;
                  done     <= 1'b1;
                end else begin
                  state <= RDWAIT;
                end
              end
              default: begin
                status_r <= pai_pkg::ST_RANGE;
                done     <= 1'b1;
              end
            endcase
          end
        end
        SHIFT: begin
          // read at ptr now, write its neighbour slot next cycle
          pend_valid <= 1'b1;
          pend_addr  <= ins ? ptr + 1'b1 : ptr - 1'b1;
          if (ptr == last) begin
            state <= DRAIN;
          end else begin
            ptr <= ins ? ptr - 1'b1 : ptr + 1'b1;
          end
        end
        DRAIN: begin
          pend_valid <= 1'b0;
          if (ins) begin
            state <= PUT;
          end else begin
            count <= count - 1'b1;
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        PUT: begin
          count <= count + 1'b1;
          done  <= 1'b1;
          state <= IDLE;
        end
        RDWAIT: begin
          rd_r  <= mem_rdata;
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= pai_pkg::CNT_W'(pai_pkg::CAPACITY))
    else $error("count above capacity");
  a_put_port: assert property (@(posedge clk) disable iff (rst)
    (state == PUT) |-> !pend_valid)
    else $error("write port conflict in final write");
  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == SHIFT || state == DRAIN))
    else $error("pending write outside shift");

endmodule

`default_nettype wire

/* rtl/positional_array_insert_delete_top.sv */
// Top level of the positional array insert/delete block.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------
//  request   | start, busy          | req (req_type, position, value)
//  result    | done (one-cycle)     | res (status, read_value, element_count)
//
// Rejected requests report in the cycle after acceptance; a read reports via RDWAIT.
// An insert that moves entries runs SHIFT, DRAIN and PUT, an append only PUT, a delete
// that moves entries SHIFT and DRAIN, a delete of the last entry never raises busy;
// the single RAM write port moves one entry a cycle.
// rst clears the count and the sequencer; RAM contents are undefined until written.
// The receiver cannot stall: each result stands on res for the one cycle done is high.
`default_nettype none

module positional_array_insert_delete_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire pai_pkg::req_t req,
  output logic               done,
  output pai_pkg::res_t      res
);

  logic                           mem_we;
  logic [pai_pkg::ADDR_W-1:0]     mem_waddr;
  logic [pai_pkg::WORD_W-1:0]     mem_wdata;
  logic [pai_pkg::ADDR_W-1:0]     mem_raddr;
  logic [pai_pkg::WORD_W-1:0]     mem_rdata;

  pai_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pai_ram #(
    .WIDTH (pai_pkg::WORD_W),
    .DEPTH (pai_pkg::CAPACITY),
    .AW    (pai_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
